/* rtl/pdd_pkg.sv */
// Package with register indexes, field widths and fixed constants for the PID drive block.
package pdd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SETPOINT   = 3'd0;
  localparam logic [2:0] REG_KP_GAIN    = 3'd1;
  localparam logic [2:0] REG_KI_GAIN    = 3'd2;
  localparam logic [2:0] REG_KD_GAIN    = 3'd3;
  localparam logic [2:0] REG_PWM_PERIOD = 3'd4;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 32;
  localparam int PERIOD_W = 24;
  localparam int DUTY_W   = 20;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int DERIV_W  = ERR_W + 1;
  localparam int BASE_W   = 23;
  localparam int NUM_W    = 56;

  // Reset values of the configuration registers.
  localparam logic signed [SAMPLE_W-1:0] SETPOINT_RST   = 16'sd162;
  localparam logic signed [GAIN_W-1:0]   KP_GAIN_RST    = 32'sd461028;
  localparam logic signed [GAIN_W-1:0]   KI_GAIN_RST    = -32'sd596;
  localparam logic signed [GAIN_W-1:0]   KD_GAIN_RST    = 32'sd2074;
  localparam logic [PERIOD_W-1:0]        PWM_PERIOD_RST = 24'd1000000;

  // Reciprocal of 5 scaled by 2^27; exact floor for dividends below 2^26.
  localparam int                DIV5_SHIFT = 27;
  localparam logic [24:0]       DIV5_MULT  = 25'd26843546;

endpackage

/* rtl/pid_differential_drive.sv */
// Positional PID steering with clamped integral for a two-wheel differential drive.
//
//   channel   dir   fields
//   s_*       in    tuser: mode; tdata: sample
//   m_*       out   tdata: left_forward, left_duty, right_forward, right_duty
//   cfg_*     in    register index and write data
//
// One item per cycle while the output is not stalled.
// The error, integral clamp and derivative are formed in the accept cycle, so the
// state is ready for the next item at once. Products, sums and saturation follow in
// three registered stages. Each stage holds its item while the next one is full and
// cannot pass its item on, so while a result waits the block takes items until all
// four stages hold one. Mode 1 items clear the state and produce no result. Reset
// (rst, synchronous) restores the register defaults.
module pid_differential_drive
  import pdd_pkg::*;
#(
  parameter int DUTY_LIMIT     = 1000000,
  parameter int INTEGRAL_LIMIT = 3000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [0] left_forward, [20:1] left_duty,
                                 // [21] right_forward, [41:22] right_duty, rest zero
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int INT_W   = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam int ISUM_W  = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
  localparam int PKP_W   = GAIN_W + ERR_W;
  localparam int PKI_W   = GAIN_W + INT_W;
  localparam int PKD_W   = GAIN_W + DERIV_W;
  localparam int MAG_W   = NUM_W - 8;
  localparam logic signed [ISUM_W-1:0] ILIM_POS = ISUM_W'(INTEGRAL_LIMIT);
  localparam logic signed [ISUM_W-1:0] ILIM_NEG = -ISUM_W'(INTEGRAL_LIMIT);
  localparam logic [MAG_W-1:0]         DLIM     = MAG_W'(DUTY_LIMIT);

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] setpoint;
  logic signed [GAIN_W-1:0]   kp_gain;
  logic signed [GAIN_W-1:0]   ki_gain;
  logic signed [GAIN_W-1:0]   kd_gain;
  logic [PERIOD_W-1:0]        pwm_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= SETPOINT_RST;
      kp_gain    <= KP_GAIN_RST;
      ki_gain    <= KI_GAIN_RST;
      kd_gain    <= KD_GAIN_RST;
      pwm_period <= PWM_PERIOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SETPOINT:   setpoint   <= cfg_wdata[SAMPLE_W-1:0];
        REG_KP_GAIN:    kp_gain    <= cfg_wdata;
        REG_KI_GAIN:    ki_gain    <= cfg_wdata;
        REG_KD_GAIN:    kd_gain    <= cfg_wdata;
        REG_PWM_PERIOD: pwm_period <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Base speeds: a quarter of the period, and two fifths by reciprocal multiply.
  logic [BASE_W-1:0]      base_left;
  logic [BASE_W-1:0]      base_right;
  logic [PERIOD_W+25:0]   div5_prod;

  assign div5_prod = {1'b0, pwm_period, 1'b0} * {1'b0, DIV5_MULT};

  always_ff @(posedge clk) begin
    base_left  <= BASE_W'(pwm_period[PERIOD_W-1:2]);
    base_right <= div5_prod[DIV5_SHIFT+BASE_W-1:DIV5_SHIFT];
  end

  // Stage handshakes: a stage takes a new item when it is empty or its item moves on.
  logic valid1, valid2, valid3;
  logic ready2, ready3, ready4;
  logic in_take;

  assign ready4   = !m_tvalid || m_tready;
  assign ready3   = !valid3 || ready4;
  assign ready2   = !valid2 || ready3;
  assign s_tready = !valid1 || ready2;
  assign in_take  = s_tvalid && s_tready;

  // Error, clamped integral and derivative against the running state.
  logic signed [INT_W-1:0]   integral_sum;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [ERR_W-1:0]   err;
  logic signed [ISUM_W-1:0]  isum_raw;
  logic signed [INT_W-1:0]   isum;
  logic signed [DERIV_W-1:0] deriv;

  always_comb begin
    err      = ERR_W'(setpoint) - ERR_W'($signed(s_tdata));
    isum_raw = ISUM_W'(integral_sum) + ISUM_W'(err);
    priority if (isum_raw > ILIM_POS) begin
      isum = INT_W'(ILIM_POS);
    end else if (isum_raw < ILIM_NEG) begin
      isum = INT_W'(ILIM_NEG);
    end else begin
      isum = INT_W'(isum_raw);
    end
    deriv = DERIV_W'(err) - DERIV_W'(last_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
    end else if (in_take) begin
      if (s_tuser) begin
        integral_sum <= '0;
        last_error   <= '0;
      end else begin
        integral_sum <= isum;
        last_error   <= err;
      end
    end
  end

  // Stage 1: terms of the correction.
  logic signed [ERR_W-1:0]   err1;
  logic signed [INT_W-1:0]   isum1;
  logic signed [DERIV_W-1:0] deriv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (s_tready) begin
      valid1 <= s_tvalid && !s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && !s_tuser) begin
      err1   <= err;
      isum1  <= isum;
      deriv1 <= deriv;
    end
  end

  // Stage 2: the three gain products.
  logic signed [PKP_W-1:0] prod_kp;
  logic signed [PKI_W-1:0] prod_ki;
  logic signed [PKD_W-1:0] prod_kd;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (ready2) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (valid1 && ready2) begin
      prod_kp <= PKP_W'(kp_gain) * PKP_W'(err1);
      prod_ki <= PKI_W'(ki_gain) * PKI_W'(isum1);
      prod_kd <= PKD_W'(kd_gain) * PKD_W'(deriv1);
    end
  end

  // Stage 3: drive values in Q.8 for both sides.
  logic signed [NUM_W-1:0] corr;
  logic signed [NUM_W-1:0] left_num;
  logic signed [NUM_W-1:0] right_num;

  assign corr = NUM_W'(prod_kp) + NUM_W'(prod_ki) + NUM_W'(prod_kd);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (ready3) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (valid2 && ready3) begin
      left_num  <= $signed({{(NUM_W-BASE_W-8){1'b0}}, base_left, 8'b0}) - corr;
      right_num <= $signed({{(NUM_W-BASE_W-8){1'b0}}, base_right, 8'b0}) + corr;
    end
  end

  // Stage 4: truncate toward zero, split into direction and saturated magnitude.
  logic [NUM_W-1:0] left_abs, right_abs;
  logic [MAG_W-1:0] left_mag, right_mag;
  logic [MAG_W-1:0] left_sat, right_sat;
  logic             left_fwd, right_fwd;

  always_comb begin
    left_abs  = left_num[NUM_W-1] ? NUM_W'(-left_num) : NUM_W'(left_num);
    right_abs = right_num[NUM_W-1] ? NUM_W'(-right_num) : NUM_W'(right_num);
    left_mag  = left_abs[NUM_W-1:8];
    right_mag = right_abs[NUM_W-1:8];
    left_sat  = (left_mag > DLIM) ? DLIM : left_mag;
    right_sat = (right_mag > DLIM) ? DLIM : right_mag;
    // A value between -1 and 0 truncates to zero and counts as forward.
    left_fwd  = !left_num[NUM_W-1] || (left_mag == '0);
    right_fwd = !right_num[NUM_W-1] || (right_mag == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready4) begin
      m_tvalid <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (valid3 && ready4) begin
      m_tdata <= {6'b0, right_sat[DUTY_W-1:0], right_fwd, left_sat[DUTY_W-1:0], left_fwd};
    end
  end

endmodule
